// ===== hdl/baro_temp_pressure_compensation_top_defines.svh =====
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top_defines
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define BTPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, masked while reset is low
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked through reset as well
`define BTPC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/btpc_pkg.sv =====
// ----------------------------------------------------------------------------
// btpc_pkg
// Types and constants of the barometric temperature/pressure compensation.
// ----------------------------------------------------------------------------
package btpc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CAL_TEMP       = 2'd0;
    localparam logic [1:0] CFG_CAL_PRESS_LO   = 2'd1;
    localparam logic [1:0] CFG_CAL_PRESS_HI   = 2'd2;
    localparam logic [1:0] CFG_CAL_PRESS_LAST = 2'd3;

    // formula constants
    localparam logic [63:0] OFFSET_FINE = 64'd128000;
    localparam logic [63:0] PRESS_BASE  = 64'd1048576;
    localparam logic [63:0] PRESS_SCALE = 64'd3125;
    localparam logic [31:0] ROUND_HALF  = 32'd128;
    localparam logic [63:0] ONE_47      = 64'h0000_8000_0000_0000;

    typedef struct packed {
        logic [19:0] raw_temp;
        logic [19:0] raw_press;
    } t_in;

    typedef struct packed {
        logic signed [31:0] fine_temp;
        logic signed [23:0] temp_centi;
        logic [31:0]        press_q24_8;
        logic               div_zero;
    } t_out;

    typedef struct packed {
        logic [47:0] cal_temp;
        logic [63:0] cal_press_lo;
        logic [63:0] cal_press_hi;
        logic [15:0] cal_press_last;
    } t_cal;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;

endpackage

// ===== hdl/btpc_front.sv =====
// ----------------------------------------------------------------------------
// btpc_front
// Input acceptance and a two-entry queue toward the compute sequencer.
// ----------------------------------------------------------------------------
module btpc_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  btpc_pkg::t_in  i_in,
    output logic           o_q_valid,
    output btpc_pkg::t_in  o_q_item,
    input  logic           i_q_pop
);

    btpc_pkg::t_in r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign w_pop     = i_q_pop && o_q_valid;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_in;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== hdl/btpc_mul.sv =====
// ----------------------------------------------------------------------------
// btpc_mul
// 64x64 multiply modulo 2^64 from three 32x32 partial products.
// ----------------------------------------------------------------------------
module btpc_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_mul_req  i_req,
    output logic                o_done,
    output logic [63:0]         o_prod
);

    logic [63:0] r_a;
    logic [63:0] r_b;
    logic [2:0]  r_ph;
    logic [63:0] r_pp;
    logic [63:0] r_acc;
    logic        r_done;
    logic [31:0] w_ma;
    logic [31:0] w_mb;

    // operand halves per phase: lo*lo, lo*hi, hi*lo
    assign w_ma = (r_ph == 3'd3) ? r_a[63:32] : r_a[31:0];
    assign w_mb = (r_ph == 3'd2) ? r_b[63:32] : r_b[31:0];

    assign o_done = r_done;
    assign o_prod = r_acc;

    // partial product and accumulate
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        r_pp <= w_ma * w_mb;
        case (r_ph)
            3'd2:    r_acc <= r_pp;
            3'd3:    r_acc <= r_acc + {r_pp[31:0], 32'd0};
            3'd4:    r_acc <= r_acc + {r_pp[31:0], 32'd0};
            default: r_acc <= r_acc;
        endcase
    end

    // phase control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_ph == 3'd4);
            if (i_req.start) begin
                r_ph <= 3'd1;
            end else if (r_ph == 3'd4) begin
                r_ph <= 3'd0;
            end else if (r_ph != 3'd0) begin
                r_ph <= r_ph + 3'd1;
            end
        end
    end

endmodule

// ===== hdl/btpc_div.sv =====
// ----------------------------------------------------------------------------
// btpc_div
// Signed 64-bit divide, truncating toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module btpc_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  btpc_pkg::t_div_req  i_req,
    output logic                o_done,
    output logic [63:0]         o_quo
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_q;
    logic [63:0] r_mden;
    logic        r_neg;
    logic [64:0] w_sh;
    logic [64:0] w_diff;

    // restoring step
    assign w_sh   = {r_rem, r_q[63]};
    assign w_diff = w_sh - {1'b0, r_mden};

    assign o_done = r_done;
    assign o_quo  = r_neg ? (64'd0 - r_q) : r_q;

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_neg  <= i_req.num[63] ^ i_req.den[63];
            r_mden <= i_req.den[63] ? (64'd0 - i_req.den) : i_req.den;
            r_q    <= i_req.num[63] ? (64'd0 - i_req.num) : i_req.num;
            r_rem  <= 64'd0;
        end else if (r_busy) begin
            if (!w_diff[64]) begin
                r_rem <= w_diff[63:0];
                r_q   <= {r_q[62:0], 1'b1};
            end else begin
                r_rem <= w_sh[63:0];
                r_q   <= {r_q[62:0], 1'b0};
            end
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                if (r_cnt == 6'd0) r_busy <= 1'b0;
                r_cnt <= r_cnt - 6'd1;
            end
        end
    end

endmodule

// ===== hdl/btpc_back.sv =====
// ----------------------------------------------------------------------------
// btpc_back
// Compute sequencer: runs the compensation steps on the shared multiplier
// and divider and holds the result register.
// ----------------------------------------------------------------------------
module btpc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  btpc_pkg::t_cal  i_cal,
    input  logic            i_q_valid,
    input  btpc_pkg::t_in   i_q_item,
    output logic            o_q_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output btpc_pkg::t_out  o_out
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    // multiply steps
    localparam logic [3:0] OP_X_T2    = 4'd0;
    localparam logic [3:0] OP_DD      = 4'd1;
    localparam logic [3:0] OP_T3      = 4'd2;
    localparam logic [3:0] OP_AA      = 4'd3;
    localparam logic [3:0] OP_AA_P6   = 4'd4;
    localparam logic [3:0] OP_A_P5    = 4'd5;
    localparam logic [3:0] OP_AA_P3   = 4'd6;
    localparam logic [3:0] OP_A_P2    = 4'd7;
    localparam logic [3:0] OP_P1      = 4'd8;
    localparam logic [3:0] OP_N_SCALE = 4'd9;
    localparam logic [3:0] OP_P9_PS   = 4'd10;
    localparam logic [3:0] OP_C_PS    = 4'd11;
    localparam logic [3:0] OP_P8_P    = 4'd12;

    logic [1:0]  r_state;
    logic [3:0]  r_op;
    logic        r_issued;
    logic [19:0] r_at;
    logic [19:0] r_ap;
    logic [31:0] r_v1;
    logic [31:0] r_t32;
    logic [31:0] r_fine;
    logic [63:0] r_aa;
    logic [63:0] r_b;
    logic [63:0] r_t64;
    logic [63:0] r_den;
    logic [63:0] r_num;
    logic [63:0] r_p;
    logic [63:0] r_c;
    logic        r_dz;
    logic        r_ov;
    btpc_pkg::t_out r_out;

    btpc_pkg::t_mul_req w_mreq;
    btpc_pkg::t_div_req w_dreq;
    logic        w_mdone;
    logic [63:0] w_prod;
    logic        w_ddone;
    logic [63:0] w_quo;

    // calibration words
    logic [31:0] w_t1;
    logic [31:0] w_t2;
    logic [31:0] w_t3;
    logic [63:0] w_p1, w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;
    logic [31:0] w_x;
    logic [31:0] w_d;
    logic [63:0] w_a;
    logic [63:0] w_ps;
    logic [63:0] w_n;
    logic [31:0] w_fine5;
    logic [31:0] w_centi;
    logic [63:0] w_press;
    logic        w_out_free;

    assign w_t1 = {16'd0, i_cal.cal_temp[15:0]};
    assign w_t2 = {{16{i_cal.cal_temp[31]}}, i_cal.cal_temp[31:16]};
    assign w_t3 = {{16{i_cal.cal_temp[47]}}, i_cal.cal_temp[47:32]};
    assign w_p1 = {48'd0, i_cal.cal_press_lo[15:0]};
    assign w_p2 = {{48{i_cal.cal_press_lo[31]}}, i_cal.cal_press_lo[31:16]};
    assign w_p3 = {{48{i_cal.cal_press_lo[47]}}, i_cal.cal_press_lo[47:32]};
    assign w_p4 = {{48{i_cal.cal_press_lo[63]}}, i_cal.cal_press_lo[63:48]};
    assign w_p5 = {{48{i_cal.cal_press_hi[15]}}, i_cal.cal_press_hi[15:0]};
    assign w_p6 = {{48{i_cal.cal_press_hi[31]}}, i_cal.cal_press_hi[31:16]};
    assign w_p7 = {{48{i_cal.cal_press_hi[47]}}, i_cal.cal_press_hi[47:32]};
    assign w_p8 = {{48{i_cal.cal_press_hi[63]}}, i_cal.cal_press_hi[63:48]};
    assign w_p9 = {{48{i_cal.cal_press_last[15]}}, i_cal.cal_press_last};

    // derived operands
    assign w_x  = {15'd0, r_at[19:3]} - {15'd0, w_t1[15:0], 1'b0};
    assign w_d  = {16'd0, r_at[19:4]} - w_t1;
    assign w_a  = {{32{r_fine[31]}}, r_fine} - btpc_pkg::OFFSET_FINE;
    assign w_ps = 64'($signed(r_p) >>> 13);
    assign w_n  = ((btpc_pkg::PRESS_BASE - {44'd0, r_ap}) << 31) - r_b;

    // final result terms
    assign w_fine5 = (r_fine << 2) + r_fine + btpc_pkg::ROUND_HALF;
    assign w_centi = 32'($signed(w_fine5) >>> 8);
    assign w_press = 64'($signed(r_t64) >>> 8) + (w_p7 << 4);

    assign w_out_free = !r_ov || i_ready;
    assign o_q_pop    = (r_state == S_IDLE) && i_q_valid;
    assign o_valid    = r_ov;
    assign o_out      = r_out;

    // multiplier request
    always_comb begin
        w_mreq.start = (r_state == S_MUL) && !r_issued;
        case (r_op)
            OP_X_T2:    begin w_mreq.a = {32'd0, w_x};   w_mreq.b = {32'd0, w_t2}; end
            OP_DD:      begin w_mreq.a = {32'd0, w_d};   w_mreq.b = {32'd0, w_d};  end
            OP_T3:      begin w_mreq.a = {32'd0, r_t32}; w_mreq.b = {32'd0, w_t3}; end
            OP_AA:      begin w_mreq.a = w_a;  w_mreq.b = w_a;  end
            OP_AA_P6:   begin w_mreq.a = r_aa; w_mreq.b = w_p6; end
            OP_A_P5:    begin w_mreq.a = w_a;  w_mreq.b = w_p5; end
            OP_AA_P3:   begin w_mreq.a = r_aa; w_mreq.b = w_p3; end
            OP_A_P2:    begin w_mreq.a = w_a;  w_mreq.b = w_p2; end
            OP_P1:      begin w_mreq.a = btpc_pkg::ONE_47 + r_t64; w_mreq.b = w_p1; end
            OP_N_SCALE: begin w_mreq.a = w_n;  w_mreq.b = btpc_pkg::PRESS_SCALE; end
            OP_P9_PS:   begin w_mreq.a = w_p9; w_mreq.b = w_ps; end
            OP_C_PS:    begin w_mreq.a = r_t64; w_mreq.b = w_ps; end
            OP_P8_P:    begin w_mreq.a = w_p8; w_mreq.b = r_p;  end
            default:    begin w_mreq.a = 64'd0; w_mreq.b = 64'd0; end
        endcase
    end

    // divider request
    always_comb begin
        w_dreq.start = (r_state == S_DIV) && !r_issued;
        w_dreq.num   = r_num;
        w_dreq.den   = r_den;
    end

    btpc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mreq),
        .o_done  (w_mdone),
        .o_prod  (w_prod)
    );

    btpc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    // datapath captures
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_at <= i_q_item.raw_temp;
            r_ap <= i_q_item.raw_press;
        end
        if ((r_state == S_MUL) && r_issued && w_mdone) begin
            case (r_op)
                OP_X_T2:    r_v1  <= 32'($signed(w_prod[31:0]) >>> 11);
                OP_DD:      r_t32 <= 32'($signed(w_prod[31:0]) >>> 12);
                OP_T3:      r_fine <= r_v1 + 32'($signed(w_prod[31:0]) >>> 14);
                OP_AA:      r_aa  <= w_prod;
                OP_AA_P6:   r_b   <= w_prod + (w_p4 << 35);
                OP_A_P5:    r_b   <= r_b + (w_prod << 17);
                OP_AA_P3:   r_t64 <= 64'($signed(w_prod) >>> 8);
                OP_A_P2:    r_t64 <= r_t64 + (w_prod << 12);
                OP_P1:      r_den <= 64'($signed(w_prod) >>> 33);
                OP_N_SCALE: r_num <= w_prod;
                OP_P9_PS:   r_t64 <= w_prod;
                OP_C_PS:    r_c   <= 64'($signed(w_prod) >>> 25);
                OP_P8_P:    r_t64 <= r_p + r_c + 64'($signed(w_prod) >>> 19);
                default:    r_t64 <= r_t64;
            endcase
        end
        if ((r_state == S_DIV) && r_issued && w_ddone) begin
            r_p <= w_quo;
        end
        // result register
        if ((r_state == S_FIN) && w_out_free) begin
            r_out.fine_temp   <= r_fine;
            r_out.temp_centi  <= w_centi[23:0];
            r_out.press_q24_8 <= r_dz ? 32'd0 : w_press[31:0];
            r_out.div_zero    <= r_dz;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_op     <= OP_X_T2;
            r_issued <= 1'b0;
            r_dz     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state  <= S_MUL;
                        r_op     <= OP_X_T2;
                        r_issued <= 1'b0;
                    end
                end
                S_MUL: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_mdone) begin
                        r_issued <= 1'b0;
                        r_op     <= r_op + 4'd1;
                        if (r_op == OP_N_SCALE) begin
                            r_dz    <= (r_den == 64'd0);
                            r_state <= (r_den == 64'd0) ? S_FIN : S_DIV;
                        end else if (r_op == OP_P8_P) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DIV: begin
                    if (!r_issued) begin
                        r_issued <= 1'b1;
                    end else if (w_ddone) begin
                        r_issued <= 1'b0;
                        r_state  <= S_MUL;
                        r_op     <= OP_P9_PS;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_ov    <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/baro_temp_pressure_compensation_top.sv =====
// Each item takes thirteen passes through the shared multiplier, built from
// 32x32 partial products, and one through the bit-serial divider; when the
// pressure divisor is zero the divider is skipped and ten passes suffice.
// The sequencer takes the next item only once the last result is registered.
// A two-entry input queue and the result register let both sides stall alone.
// Reset (synchronous, active low) empties the queue and clears calibration.
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// Temperature and pressure compensation with calibration registers.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_idx,
    input  logic [63:0]     i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  btpc_pkg::t_in   i_in,
    output logic            o_valid,
    input  logic            i_ready,
    output btpc_pkg::t_out  o_out
);

    btpc_pkg::t_cal r_cal;
    logic           w_q_valid;
    btpc_pkg::t_in  w_q_item;
    logic           w_q_pop;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btpc_pkg::CFG_CAL_TEMP:       r_cal.cal_temp       <= i_cfg_data[47:0];
                btpc_pkg::CFG_CAL_PRESS_LO:   r_cal.cal_press_lo   <= i_cfg_data;
                btpc_pkg::CFG_CAL_PRESS_HI:   r_cal.cal_press_hi   <= i_cfg_data;
                btpc_pkg::CFG_CAL_PRESS_LAST: r_cal.cal_press_last <= i_cfg_data[15:0];
                default:                      r_cal <= r_cal;
            endcase
        end
    end

    btpc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_in      (i_in),
        .o_q_valid (w_q_valid),
        .o_q_item  (w_q_item),
        .i_q_pop   (w_q_pop)
    );

    btpc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cal     (r_cal),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_out     (o_out)
    );

endmodule

// ===== hdl/btpc_checker.sv =====
// ----------------------------------------------------------------------------
// btpc_checker
// Port-level checks of the compensation block, bound to the top level.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_top_defines.svh"

module btpc_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            o_ready,
    input  logic            o_valid,
    input  logic            i_ready,
    input  btpc_pkg::t_out  o_out
);

    // no result right after a reset cycle
    `BTPC_ASSERT_NEXT_ALWAYS(a_no_out_after_rst, i_clk, !i_rst_n, !o_valid)

    // a zero divisor always reports zero pressure
    `BTPC_ASSERT_IMPL(a_dz_press_zero, i_clk, i_rst_n, o_valid && o_out.div_zero, o_out.press_q24_8 == 32'd0)

    // a stalled result holds its value
    `BTPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_out))

    // queue accepts again once reset releases
    `BTPC_ASSERT_NEXT_ALWAYS(a_ready_after_rst, i_clk, !i_rst_n, o_ready)

endmodule

bind baro_temp_pressure_compensation_top btpc_checker u_btpc_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the temperature/pressure compensation block. Each
// item sent is run through an in-bench compensation predictor that uses the
// calibration currently loaded. Every result is compared with the oldest
// prediction. Both sides of the handshake idle at random. Calibration is
// reloaded between phases only, once the block has drained.
// ----------------------------------------------------------------------------
module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = btpc_pkg::CFG_CAL_TEMP;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    btpc_pkg::t_in  i_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    btpc_pkg::t_out o_out;

    // calibration as the bench believes it is loaded
    logic [47:0] cal_t = '0;
    logic [63:0] cal_plo = '0;
    logic [63:0] cal_phi = '0;
    logic [15:0] cal_p9 = '0;

    btpc_pkg::t_out pending_readings[$];
    int   fail_count = 0;
    bit   no_idle = 1'b0;
    int   sink_wait = 0;

    baro_temp_pressure_compensation_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #8ms;
        $display("TEST FAILED");
        $finish;
    end

    // compensation predictor: 32-bit temperature, 64-bit pressure, both wrapping
    function automatic btpc_pkg::t_out compensate(btpc_pkg::t_in x);
        logic signed [31:0] rt, t1, t2, t3, tmp, dd, v1, v2, fine, centi;
        logic signed [63:0] a, b, a2, a3, n, p, ps, c, e, ap;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        btpc_pkg::t_out r;
        rt = {12'd0, x.raw_temp};
        t1 = {16'd0, cal_t[15:0]};
        t2 = $signed(cal_t[31:16]);
        t3 = $signed(cal_t[47:32]);
        tmp = ((rt >>> 3) - (t1 <<< 1)) * t2;
        v1 = tmp >>> 11;
        dd = (rt >>> 4) - t1;
        tmp = (dd * dd) >>> 12;
        v2 = (tmp * t3) >>> 14;
        fine = v1 + v2;
        centi = (fine * 32'sd5 + 32'sd128) >>> 8;

        p1 = {48'd0, cal_plo[15:0]};
        p2 = $signed(cal_plo[31:16]);
        p3 = $signed(cal_plo[47:32]);
        p4 = $signed(cal_plo[63:48]);
        p5 = $signed(cal_phi[15:0]);
        p6 = $signed(cal_phi[31:16]);
        p7 = $signed(cal_phi[47:32]);
        p8 = $signed(cal_phi[63:48]);
        p9 = $signed(cal_p9);

        a = fine;
        a = a - 64'sd128000;
        b = a * a * p6 + ((a * p5) <<< 17) + (p4 <<< 35);
        a2 = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
        a3 = ((64'sh0000_8000_0000_0000 + a2) * p1) >>> 33;

        r.fine_temp = fine;
        r.temp_centi = centi[23:0];
        r.press_q24_8 = '0;
        r.div_zero = 1'b1;
        if (a3 != 64'sd0) begin
            ap = {44'd0, x.raw_press};
            n = (((64'sd1048576 - ap) <<< 31) - b) * 64'sd3125;
            // most negative over -1 wraps
            if (n == 64'sh8000_0000_0000_0000 && a3 == -64'sd1)
                p = n;
            else
                p = n / a3;
            ps = p >>> 13;
            c = (p9 * ps * ps) >>> 25;
            e = (p8 * p) >>> 19;
            p = ((p + c + e) >>> 8) + (p7 <<< 4);
            r.press_q24_8 = p[31:0];
            r.div_zero = 1'b0;
        end
        return r;
    endfunction

    // result side: random stalls, compare against the oldest prediction
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_readings.size() == 0) begin
                    $error("result item with no prediction waiting");
                    fail_count++;
                end else begin
                    btpc_pkg::t_out w;
                    w = pending_readings.pop_front();
                    if (o_out.fine_temp !== w.fine_temp) begin
                        $error("fine_temp expected %0d got %0d", w.fine_temp, o_out.fine_temp);
                        fail_count++;
                    end
                    if (o_out.temp_centi !== w.temp_centi) begin
                        $error("temp_centi expected %0d got %0d",
                               w.temp_centi, o_out.temp_centi);
                        fail_count++;
                    end
                    if (o_out.press_q24_8 !== w.press_q24_8) begin
                        $error("press_q24_8 expected %h got %h",
                               w.press_q24_8, o_out.press_q24_8);
                        fail_count++;
                    end
                    if (o_out.div_zero !== w.div_zero) begin
                        $error("div_zero expected %0b got %0b", w.div_zero, o_out.div_zero);
                        fail_count++;
                    end
                end
                sink_wait = no_idle ? 0 : $urandom_range(0, 3);
                i_ready <= (sink_wait == 0);
            end else if (!i_ready) begin
                if (sink_wait > 0)
                    sink_wait--;
                if (sink_wait == 0)
                    i_ready <= 1'b1;
            end
        end
    end

    // send one item; valid stays high afterwards unless the next gap drops it
    task automatic send_item(input btpc_pkg::t_in x);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in <= x;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(compensate(x));
    endtask

    task automatic send_raw(input logic [19:0] t, input logic [19:0] p);
        btpc_pkg::t_in x;
        x.raw_temp = t;
        x.raw_press = p;
        send_item(x);
    endtask

    // let the block drain before touching calibration
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cal(input logic [1:0] idx, input logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            btpc_pkg::CFG_CAL_TEMP:       cal_t = data[47:0];
            btpc_pkg::CFG_CAL_PRESS_LO:   cal_plo = data;
            btpc_pkg::CFG_CAL_PRESS_HI:   cal_phi = data;
            btpc_pkg::CFG_CAL_PRESS_LAST: cal_p9 = data[15:0];
            default:                      cal_t = cal_t;
        endcase
    endtask

    task automatic load_cal(input logic [63:0] ct, input logic [63:0] plo,
                            input logic [63:0] phi, input logic [63:0] p9);
        drain();
        write_cal(btpc_pkg::CFG_CAL_TEMP, ct);
        write_cal(btpc_pkg::CFG_CAL_PRESS_LO, plo);
        write_cal(btpc_pkg::CFG_CAL_PRESS_HI, phi);
        write_cal(btpc_pkg::CFG_CAL_PRESS_LAST, p9);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // typical factory words
    localparam logic [63:0] TYP_T   = {16'd0, 16'hFC18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLO = {16'd2855, 16'd3024, 16'hD643, 16'd36477};
    localparam logic [63:0] TYP_PHI = {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140};
    localparam logic [63:0] TYP_P9  = 64'd6000;

    // all-zero calibration after reset: divisor is zero
    task automatic test_reset_values;
        send_raw(20'h00000, 20'h00000);
        send_raw(20'hFFFFF, 20'hFFFFF);
        send_raw(20'd519888, 20'd415148);
    endtask

    // typical calibration with field extremes
    task automatic test_typical;
        load_cal(TYP_T, TYP_PLO, TYP_PHI, TYP_P9);
        send_raw(20'd519888, 20'd415148);
        send_raw(20'h00000, 20'h00000);
        send_raw(20'hFFFFF, 20'hFFFFF);
        send_raw(20'h00000, 20'hFFFFF);
        send_raw(20'hFFFFF, 20'h00000);
        send_raw(20'hAAAAA, 20'h55555);
        send_raw(20'h55555, 20'hAAAAA);
    endtask

    // extreme calibration words
    task automatic test_extreme_cal;
        load_cal('1, '1, '1, '1);
        send_raw(20'h00000, 20'h00000);
        send_raw(20'hFFFFF, 20'hFFFFF);
        load_cal({16'd0, 16'h7FFF, 16'h8000, 16'hFFFF}, 64'h8000_7FFF_8000_FFFF,
                 64'h7FFF_8000_7FFF_8000, 64'h0000_0000_0000_8000);
        send_raw(20'h00000, 20'hFFFFF);
        send_raw(20'hFFFFF, 20'h00000);
        load_cal({16'd0, 16'h8000, 16'h7FFF, 16'h0000}, 64'h7FFF_8000_7FFF_0001,
                 64'h8000_7FFF_8000_7FFF, 64'h0000_0000_0000_7FFF);
        send_raw(20'h00000, 20'h00000);
        send_raw(20'hFFFFF, 20'hFFFFF);
        // P1 of zero forces the zero divisor
        load_cal(TYP_T, TYP_PLO & ~64'hFFFF, TYP_PHI, TYP_P9);
        send_raw(20'd519888, 20'd415148);
    endtask

    // random phases: near-typical words and fully random words
    task automatic test_random;
        logic [63:0] jt, jlo, jhi;
        for (int ph = 0; ph < 12; ph++) begin
            if (ph % 2 == 0) begin
                jt = {$urandom(), $urandom()} & 64'h0000_00FF_00FF_00FF;
                jlo = rand64() & 64'h00FF_00FF_00FF_00FF;
                jhi = rand64() & 64'h00FF_00FF_00FF_00FF;
                load_cal(TYP_T ^ jt, TYP_PLO ^ jlo, TYP_PHI ^ jhi,
                         TYP_P9 ^ 64'($urandom() & 32'h0000_00FF));
            end else begin
                load_cal(rand64(), rand64(), rand64(), rand64());
            end
            no_idle = (ph == 5);
            for (int k = 0; k < 50; k++) begin
                if (ph % 2 == 0)
                    send_raw(20'($urandom_range(300000, 700000)),
                             20'($urandom_range(200000, 600000)));
                else
                    send_raw(20'($urandom()), 20'($urandom()));
            end
            no_idle = 1'b0;
        end
    endtask

    // main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        i_ready <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_typical();
        test_extreme_cal();
        test_random();
        drain();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
